/* rtl/core/eph_pkg.sv */
// ----------------------------------------------------------------------------
// eph_pkg
// shared types and constants of the edge proximity hit test
// ----------------------------------------------------------------------------
package eph_pkg;

    localparam int EDGE_SLOTS = 64;
    localparam int SLOT_W     = $clog2(EDGE_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int COORD_W    = 16;
    localparam int TOL_W      = 8;
    localparam int ECOUNT_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TOL_W-1:0] MIN_TOLERANCE = TOL_W'(2);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_X_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_X_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_Y_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_Y_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAB_TOLERANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT     = 3'd5;

    // item kinds
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic [5:0]                 slot;
        logic signed [COORD_W-1:0]  end_a_x;
        logic signed [COORD_W-1:0]  end_a_y;
        logic signed [COORD_W-1:0]  end_b_x;
        logic signed [COORD_W-1:0]  end_b_y;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
    } item_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] hit_slot;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } edge_rec_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] x_max;
        logic signed [COORD_W-1:0] y_min;
        logic signed [COORD_W-1:0] y_max;
    } bounds_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

endpackage

/* rtl/core/eph_match.sv */
// ----------------------------------------------------------------------------
// eph_match
// tests one stored edge against the pointer, bounds and tolerance
// ----------------------------------------------------------------------------
module eph_match
    import eph_pkg::*;
(
    input  edge_rec_t          edge_rec,
    input  point_t             point,
    input  bounds_t            bounds,
    input  logic [TOL_W-1:0]   tol,
    output logic               match
);

    logic                      horiz;
    logic signed [COORD_W:0]   line_c;
    logic signed [COORD_W:0]   lo_b;
    logic signed [COORD_W:0]   hi_b;
    logic signed [COORD_W:0]   p_line;
    logic signed [COORD_W:0]   p_span;
    logic signed [COORD_W:0]   e0;
    logic signed [COORD_W:0]   e1;
    logic signed [COORD_W+1:0] diff;
    logic signed [COORD_W+1:0] tol_s;
    logic                      in_bounds;
    logic                      near;
    logic                      covered;

    always_comb
    begin
        horiz  = (edge_rec.ay == edge_rec.by);
        line_c = horiz ? (COORD_W+1)'(edge_rec.ay) : (COORD_W+1)'(edge_rec.ax);
        lo_b   = horiz ? (COORD_W+1)'(bounds.y_min) : (COORD_W+1)'(bounds.x_min);
        hi_b   = horiz ? (COORD_W+1)'(bounds.y_max) : (COORD_W+1)'(bounds.x_max);
        p_line = horiz ? (COORD_W+1)'(point.y) : (COORD_W+1)'(point.x);
        p_span = horiz ? (COORD_W+1)'(point.x) : (COORD_W+1)'(point.y);
        e0     = horiz ? (COORD_W+1)'(edge_rec.ax) : (COORD_W+1)'(edge_rec.ay);
        e1     = horiz ? (COORD_W+1)'(edge_rec.bx) : (COORD_W+1)'(edge_rec.by);

        // upper bound less one, kept signed and wide
        in_bounds = (line_c > lo_b) && (line_c < (hi_b - (COORD_W+1)'(1)));

        diff  = (COORD_W+2)'(p_line) - (COORD_W+2)'(line_c);
        tol_s = signed'({{(COORD_W+2-TOL_W){1'b0}}, tol});
        near  = (diff <= tol_s) && (diff >= -tol_s);

        // span either way round, ends inclusive
        covered = ((p_span >= e0) && (p_span <= e1)) ||
                  ((p_span >= e1) && (p_span <= e0));

        match = in_bounds && near && covered;
    end

endmodule

/* rtl/core/edge_proximity_hit_test.sv */
// ----------------------------------------------------------------------------
// edge_proximity_hit_test
// table of axis-aligned edges with a pointer hit test over the first slots
// ----------------------------------------------------------------------------
// stores: written to the table on their transfer; a query scans slots from 0
//   upward, stops at the first hit or after n slots, then waits for the output
//   register to be free, n = edge_count clamped to the table size
// throughput: one item at a time; a query holds the input for the scan, which
//   reads one slot per cycle through the single table read port
// reset: control and configuration registers cleared (tolerance to 2); the
//   edge table is not cleared and holds nothing valid until written
// ----------------------------------------------------------------------------
module edge_proximity_hit_test
    import eph_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // item channel
    input  logic                    item_valid,
    output logic                    item_stall,
    input  item_t                   item,
    // result channel
    output logic                    result_valid,
    input  logic                    result_stall,
    output result_t                 result,
    // configuration writes
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // configuration
    bounds_t              bounds_reg;
    logic [TOL_W-1:0]     tol_cfg_reg;
    logic [ECOUNT_W-1:0]  count_cfg_reg;

    // control
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     issue_idx_reg, issue_idx_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0]    rd_slot_reg;
    logic                 pend_hit_reg, pend_hit_next;
    logic [5:0]           pend_slot_reg, pend_slot_next;
    logic                 result_valid_reg, result_valid_next;

    // query payload held for the scan
    point_t               point_reg;
    logic [TOL_W-1:0]     tol_reg;
    result_t              result_reg;

    // edge table
    edge_rec_t            edge_mem [EDGE_SLOTS];
    edge_rec_t            rd_data_reg;

    logic                 accept;
    logic                 mem_we;
    logic                 issuing;
    logic                 match;
    logic                 found;
    logic                 out_free;
    logic [CNT_W-1:0]     n_clamped;
    logic [TOL_W-1:0]     tol_eff;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign mem_we       = accept && (item.kind == KIND_STORE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    // count above the table size searches the whole table
    assign n_clamped = (int'(count_cfg_reg) > EDGE_SLOTS) ? CNT_W'(EDGE_SLOTS)
                                                          : CNT_W'(count_cfg_reg);
    // tolerance raised to at least the minimum
    assign tol_eff   = (tol_cfg_reg < MIN_TOLERANCE) ? MIN_TOLERANCE : tol_cfg_reg;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg    <= '0;
            tol_cfg_reg   <= MIN_TOLERANCE;
            count_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOUND_X_MIN:    bounds_reg.x_min <= signed'(cfg_data[COORD_W-1:0]);
                CFG_BOUND_X_MAX:    bounds_reg.x_max <= signed'(cfg_data[COORD_W-1:0]);
                CFG_BOUND_Y_MIN:    bounds_reg.y_min <= signed'(cfg_data[COORD_W-1:0]);
                CFG_BOUND_Y_MAX:    bounds_reg.y_max <= signed'(cfg_data[COORD_W-1:0]);
                CFG_GRAB_TOLERANCE: tol_cfg_reg      <= cfg_data[TOL_W-1:0];
                CFG_EDGE_COUNT:     count_cfg_reg    <= cfg_data[ECOUNT_W-1:0];
                default:            ; // unknown index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // edge table: one write port for stores, one registered read port for
    // the scan; stores are only taken while idle so the two never overlap
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            edge_mem[item.slot[SLOT_W-1:0]] <= '{ax: item.end_a_x, ay: item.end_a_y,
                                                 bx: item.end_b_x, by: item.end_b_y};
        end
        rd_data_reg <= edge_mem[issue_idx_reg[SLOT_W-1:0]];
        rd_slot_reg <= issue_idx_reg[SLOT_W-1:0];
    end

    // query payload, captured on the transfer of a query
    always_ff @(posedge clk)
    begin
        if (accept && (item.kind == KIND_QUERY))
        begin
            point_reg <= '{x: item.point_x, y: item.point_y};
            tol_reg   <= tol_eff;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            result_reg <= '{hit: pend_hit_reg, hit_slot: pend_slot_reg};
        end
    end

    // match test on the slot just read
    eph_match u_match (
        .edge_rec (rd_data_reg),
        .point    (point_reg),
        .bounds   (bounds_reg),
        .tol      (tol_reg),
        .match    (match)
    );

    assign found   = rd_valid_reg && match;
    assign issuing = (state_reg == ST_SCAN) && (issue_idx_reg < n_reg) && !found;

    // ------------------------------------------------------------------
    // scan sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        issue_idx_next    = issue_idx_reg;
        n_next            = n_reg;
        rd_valid_next     = issuing;
        pend_hit_next     = pend_hit_reg;
        pend_slot_next    = pend_slot_reg;
        result_valid_next = result_valid_reg;

        // result taken downstream
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_QUERY))
                begin
                    issue_idx_next = '0;
                    n_next         = n_clamped;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                // first match in slot order wins; later reads are dropped
                if (found)
                begin
                    pend_hit_next  = 1'b1;
                    pend_slot_next = 6'(rd_slot_reg);
                    state_next     = ST_DONE;
                end
                else if (!rd_valid_reg && (issue_idx_reg == n_reg))
                begin
                    pend_hit_next  = 1'b0;
                    pend_slot_next = '0;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to be free
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_idx_reg    <= '0;
            n_reg            <= '0;
            rd_valid_reg     <= 1'b0;
            pend_hit_reg     <= 1'b0;
            pend_slot_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_idx_reg    <= issue_idx_next;
            n_reg            <= n_next;
            rd_valid_reg     <= rd_valid_next;
            pend_hit_reg     <= pend_hit_next;
            pend_slot_reg    <= pend_slot_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the edge proximity hit test: a short scripted
// sequence, then randomised phases of stores and pointer queries mostly aimed at
// stored edges, each phase query checked against an in-bench hit predictor
// ----------------------------------------------------------------------------
module testbench;
    import eph_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // a full scan plus a margin for the result path
    localparam int SCAN_SETTLE = EDGE_SLOTS + 8;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;

    // register indexes past the end of the list, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_EDGE_COUNT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t                op;
        logic [CFG_IDX_W-1:0]     idx;
        int                       data;
        item_t                    it;
        bit                       typed;
        result_t                  want;
    } stim_row_t;

    // dut connections, all inputs known from time zero
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // shadow of the block: edge table and register copies
    edge_rec_t  edge_shadow [EDGE_SLOTS];
    int         x_lo, x_hi, y_lo, y_hi;
    int         grab_tol;
    int         edge_count_reg;

    // hit results still owed by the block, oldest first
    result_t    pending_hits [$];
    stim_row_t  script [$];

    int         mismatches  = 0;
    int         cycles      = 0;
    int         tx_gap_max  = 19;
    int         rx_gap_max  = 19;
    int         rx_wait     = 0;
    bit         cfg_busy    = 1'b0;

    edge_proximity_hit_test u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor: lowest searched slot whose edge line sits inside the
    // bounds (upper bound less one), within tolerance of the pointer,
    // and whose span covers the pointer inclusively
    // ------------------------------------------------------------------
    function automatic result_t first_hit(input int px, input int py);
        result_t    found;
        edge_rec_t  e;
        int         tol, n, line, lo_b, hi_b, near, along, s0, s1;
        found = '0;
        // tolerance below the floor acts as the floor
        tol = (grab_tol < int'(MIN_TOLERANCE)) ? int'(MIN_TOLERANCE) : grab_tol;
        // counts beyond the table search the whole table
        n = (edge_count_reg > EDGE_SLOTS) ? EDGE_SLOTS : edge_count_reg;
        for (int i = 0; i < n && !found.hit; i++)
        begin
            e = edge_shadow[i];
            if (e.ay == e.by)
            begin
                // horizontal: line is y, span along x
                line = e.ay;
                lo_b = y_lo;
                hi_b = y_hi;
                near = py;
                along = px;
                s0 = e.ax;
                s1 = e.bx;
            end
            else
            begin
                // anything else counts as vertical, line taken from endpoint a
                line = e.ax;
                lo_b = x_lo;
                hi_b = x_hi;
                near = px;
                along = py;
                s0 = e.ay;
                s1 = e.by;
            end
            if (line > lo_b && line < hi_b - 1
                && (near > line ? near - line : line - near) <= tol
                && along >= (s0 < s1 ? s0 : s1) && along <= (s0 < s1 ? s1 : s0))
            begin
                found.hit      = 1'b1;
                found.hit_slot = SLOT_W'(i);
            end
        end
        return found;
    endfunction

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    function automatic logic [COORD_W-1:0] clip16(input int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return COORD_W'(v);
    endfunction

    function automatic item_t random_item();
        logic [127:0] rnd;
        rnd = {$urandom(), $urandom(), $urandom(), $urandom()};
        return rnd[$bits(item_t)-1:0];
    endfunction

    // store of a mostly axis-aligned edge around the phase window
    function automatic item_t make_store(input int s, input int cx, input int cy,
                                         input int hs);
        item_t  x;
        int     sel;
        logic [COORD_W-1:0] line;
        x      = random_item();
        x.kind = KIND_STORE;
        x.slot = SLOT_W'(s);
        sel    = $urandom_range(19, 0);
        if (sel < 9)
        begin
            line      = clip16(pick(cy - hs - 3, cy + hs + 3));
            x.end_a_y = line;
            x.end_b_y = line;
            x.end_a_x = clip16(pick(cx - hs, cx + hs));
            x.end_b_x = clip16(pick(cx - hs, cx + hs));
        end
        else if (sel < 18)
        begin
            line      = clip16(pick(cx - hs - 3, cx + hs + 3));
            x.end_a_x = line;
            x.end_b_x = line;
            x.end_a_y = clip16(pick(cy - hs, cy + hs));
            x.end_b_y = clip16(pick(cy - hs, cy + hs));
        end
        // otherwise keep the full-range random endpoints
        return x;
    endfunction

    // ------------------------------------------------------------------
    // scripted rows
    // ------------------------------------------------------------------
    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        stim_row_t r;
        r      = '{op: ROW_REG, idx: idx, data: value, it: '0, typed: 1'b0, want: '0};
        script.push_back(r);
    endfunction

    function automatic void add_store(input int s, input int ax, input int ay,
                                      input int bx, input int by);
        stim_row_t r;
        r           = '{op: ROW_ITEM, idx: '0, data: 0, it: '0, typed: 1'b0, want: '0};
        r.it.kind    = KIND_STORE;
        r.it.slot    = SLOT_W'(s);
        r.it.end_a_x = COORD_W'(ax);
        r.it.end_a_y = COORD_W'(ay);
        r.it.end_b_x = COORD_W'(bx);
        r.it.end_b_y = COORD_W'(by);
        // point fields are don't-care on a store
        r.it.point_x = 16'h5a5a;
        r.it.point_y = 16'ha5a5;
        script.push_back(r);
    endfunction

    function automatic void add_query(input int px, input int py);
        stim_row_t r;
        r           = '{op: ROW_ITEM, idx: '0, data: 0, it: '1, typed: 1'b0, want: '0};
        r.it.kind    = KIND_QUERY;
        r.it.point_x = COORD_W'(px);
        r.it.point_y = COORD_W'(py);
        script.push_back(r);
    endfunction

    // query whose outcome is plainly a miss
    function automatic void add_miss_query(input int px, input int py);
        add_query(px, py);
        script[script.size() - 1].typed = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    // hold the item channel until all owed results have come back
    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_hits.size() != 0);
    endtask

    // register writes only ever happen with the block idle
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'(value);
        if (!cfg_busy)
        begin
            drain();
            // a trailing store may still be in flight
            repeat (SCAN_SETTLE) @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_busy   = 1'b1;
        @(posedge clk);
        case (idx)
            CFG_BOUND_X_MIN:    x_lo = $signed(d);
            CFG_BOUND_X_MAX:    x_hi = $signed(d);
            CFG_BOUND_Y_MIN:    y_lo = $signed(d);
            CFG_BOUND_Y_MAX:    y_hi = $signed(d);
            CFG_GRAB_TOLERANCE: grab_tol = d[TOL_W-1:0];
            CFG_EDGE_COUNT:     edge_count_reg = d[ECOUNT_W-1:0];
            default: ;
        endcase
    endtask

    // one transfer on the item channel, then update the shadow
    task automatic send_item(input item_t x, input bit typed, input result_t want);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
        if (cfg_busy)
        begin
            cfg_we  <= 1'b0;
            cfg_busy = 1'b0;
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= x;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        if (x.kind == KIND_STORE)
            edge_shadow[x.slot] = '{ax: x.end_a_x, ay: x.end_a_y, bx: x.end_b_x,
                                    by: x.end_b_y};
        else
            pending_hits.push_back(typed ? want : first_hit(x.point_x, x.point_y));
    endtask

    // one randomised phase: fresh registers, then a mix of stores and queries
    task automatic run_phase(input int n_items, input bit fill_first);
        item_t      x;
        edge_rec_t  e;
        int         cx, cy, hs, n, tol, s, lo, hi;
        cx = pick(-30000, 30000);
        cy = pick(-30000, 30000);
        hs = ($urandom_range(7, 0) == 0) ? pick(1000, 32000) : pick(4, 300);
        if ($urandom_range(7, 0) == 0)
        begin
            // widest bounds
            set_reg(CFG_BOUND_X_MIN, -32768);
            set_reg(CFG_BOUND_X_MAX, 32767);
            set_reg(CFG_BOUND_Y_MIN, -32768);
            set_reg(CFG_BOUND_Y_MAX, 32767);
        end
        else
        begin
            set_reg(CFG_BOUND_X_MIN, clip16(cx - hs));
            set_reg(CFG_BOUND_X_MAX, clip16(cx + hs));
            set_reg(CFG_BOUND_Y_MIN, clip16(cy - hs));
            set_reg(CFG_BOUND_Y_MAX, clip16(cy + hs));
        end
        case ($urandom_range(7, 0))
            0:       tol = 0;
            1:       tol = 1;
            2:       tol = 255;
            default: tol = pick(2, 20);
        endcase
        // junk in the unused upper data bits
        set_reg(CFG_GRAB_TOLERANCE, (int'($urandom_range(255, 0)) << TOL_W) | tol);
        case ($urandom_range(9, 0))
            0:       n = 0;
            1:       n = EDGE_SLOTS;
            2:       n = pick(EDGE_SLOTS + 1, 127);
            3:       n = 127;
            default: n = pick(1, EDGE_SLOTS);
        endcase
        set_reg(CFG_EDGE_COUNT, (int'($urandom_range(511, 0)) << ECOUNT_W) | n);
        if ($urandom_range(3, 0) == 0)
            set_reg($urandom_range(1, 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                    $urandom_range(65535, 0));

        // some phases run back to back with no idling on one or both sides
        tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 19;
        rx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 19;

        n   = (n > EDGE_SLOTS) ? EDGE_SLOTS : n;
        tol = (tol < int'(MIN_TOLERANCE)) ? int'(MIN_TOLERANCE) : tol;

        // every slot written before any query can search it
        if (fill_first)
            for (int k = 0; k < EDGE_SLOTS; k++)
                send_item(make_store(k, cx, cy, hs), 1'b0, '0);

        for (int k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2 && $urandom_range(2, 0) == 0)
                drain();
            if ($urandom_range(9, 0) < 4)
            begin
                s = (n > 0 && $urandom_range(4, 0) != 0) ? pick(0, n - 1) : pick(0, 63);
                x = make_store(s, cx, cy, hs);
            end
            else
            begin
                x      = random_item();
                x.kind = KIND_QUERY;
                if (n > 0 && $urandom_range(3, 0) != 0)
                begin
                    // aim near a searched edge, straddling the tolerance and span ends
                    e = edge_shadow[pick(0, n - 1)];
                    if (e.ay == e.by)
                    begin
                        lo = (e.ax < e.bx) ? e.ax : e.bx;
                        hi = (e.ax < e.bx) ? e.bx : e.ax;
                        x.point_y = clip16(e.ay + pick(-tol - 2, tol + 2));
                        x.point_x = clip16(pick(lo - 2, hi + 2));
                    end
                    else
                    begin
                        lo = (e.ay < e.by) ? e.ay : e.by;
                        hi = (e.ay < e.by) ? e.by : e.ay;
                        x.point_x = clip16(e.ax + pick(-tol - 2, tol + 2));
                        x.point_y = clip16(pick(lo - 2, hi + 2));
                    end
                end
                else if ($urandom_range(1, 0) != 0)
                begin
                    x.point_x = clip16(pick(cx - hs - 4, cx + hs + 4));
                    x.point_y = clip16(pick(cy - hs - 4, cy + hs + 4));
                end
                // otherwise a full-range stray pointer
            end
            send_item(x, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: checks each result transfer against the oldest owed
    // hit, and holds off for a random wait after each result
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        int      w;
        w = rx_wait;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_hits.size() == 0)
                flag_error($sformatf("unexpected result transfer: hit=%0d slot=%0d",
                                     result.hit, result.hit_slot));
            else
            begin
                want = pending_hits.pop_front();
                if (result.hit !== want.hit || result.hit_slot !== want.hit_slot)
                    flag_error($sformatf(
                        "result mismatch: expected hit=%0d slot=%0d, got hit=%0d slot=%0d",
                        want.hit, want.hit_slot, result.hit, result.hit_slot));
            end
            w = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
        end
        else if (result_valid && w > 0)
            w = w - 1;
        // the hold only counts down while a result is on offer
        rx_wait = w;
        result_stall <= (w > 0);
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        grab_tol       = 2;
        edge_count_reg = 0;
        x_lo = 0;
        x_hi = 0;
        y_lo = 0;
        y_hi = 0;

        // zero count straight after reset
        add_miss_query(-32768, 32767);

        add_reg(CFG_BOUND_X_MIN, -100);
        add_reg(CFG_BOUND_X_MAX, 100);
        add_reg(CFG_BOUND_Y_MIN, -100);
        add_reg(CFG_BOUND_Y_MAX, 100);
        add_reg(CFG_GRAB_TOLERANCE, 0);
        add_reg(CFG_EDGE_COUNT, 4);
        // horizontal with endpoints reversed, vertical, one on the upper bound less one,
        // one slanted (taken as vertical), and an unsearched extreme slot
        add_store(0, 5, 10, -5, 10);
        add_store(1, 20, 30, 20, 0);
        add_store(2, 0, 99, 50, 99);
        add_store(3, 40, -10, 60, 10);
        add_store(63, -32768, 32767, 32767, 32767);
        add_query(0, 12);
        add_query(0, 13);
        add_query(5, 8);
        add_query(6, 10);
        add_query(22, 0);
        add_query(25, 99);
        add_query(40, -10);

        // tolerance of one acts as the floor, then the widest tolerance
        add_reg(CFG_GRAB_TOLERANCE, 1);
        add_query(0, 12);
        add_reg(CFG_GRAB_TOLERANCE, 255);
        add_query(0, 200);

        // inverted extreme bounds reject everything
        add_reg(CFG_BOUND_X_MIN, 32767);
        add_reg(CFG_BOUND_X_MAX, -32768);
        add_reg(CFG_BOUND_Y_MIN, 32767);
        add_reg(CFG_BOUND_Y_MAX, -32768);
        add_miss_query(0, 10);

        // widest bounds with an edge just inside the top and full-range points
        add_reg(CFG_BOUND_X_MIN, -32768);
        add_reg(CFG_BOUND_X_MAX, 32767);
        add_reg(CFG_BOUND_Y_MIN, -32768);
        add_reg(CFG_BOUND_Y_MAX, 32767);
        add_store(0, -32768, 32765, 32767, 32765);
        add_query(-32768, 32767);
        add_query(32767, -32768);

        // writes to indexes past the list change nothing
        add_reg(CFG_SPARE_LO, 0);
        add_reg(CFG_SPARE_HI, 0);
        add_query(0, 32765);

        // count masked to seven bits lands on zero
        add_reg(CFG_EDGE_COUNT, 16'hff80);
        add_miss_query(0, 10);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            if (script[r].op == ROW_REG)
                set_reg(script[r].idx, script[r].data);
            else
                send_item(script[r].it, script[r].typed, script[r].want);
        end

        for (int p = 0; p < PHASES; p++)
            run_phase(PHASE_ITEMS, p == 0);

        drain();
        repeat (SCAN_SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* edge_proximity_hit_test.f */
rtl/core/eph_pkg.sv
rtl/core/eph_match.sv
rtl/core/edge_proximity_hit_test.sv
verif/testbench.sv
